### src/fpbs_pkg.sv
// Shared types and codes for the flash parameter block scanner.
package fpbs_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned PbW      = 12;
  localparam int unsigned RegionW  = 17;
  localparam int unsigned SeedW    = 16;
  localparam int unsigned OffW     = 16;
  localparam int unsigned WirW     = 11;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [PbW-1:0]     PbReset     = 12'd64;
  localparam logic [RegionW-1:0] RegionReset = 17'd1024;
  localparam logic [SeedW-1:0]   SeedReset   = 16'hA45E;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_CAND = 2'd2,
    PH_SKIP = 2'd3
  } scan_phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PARAM_BYTES  = 2'd0,
    CFG_REGION_WORDS = 2'd1,
    CFG_CRC_SEED     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PbW-1:0]     param_bytes;
    logic [RegionW-1:0] region_words;
    logic [SeedW-1:0]   crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [RegionW-1:0] scan_offset;
    logic [RegionW-1:0] record_start;
    logic [WirW-1:0]    word_in_record;
    scan_phase_e        phase;
    logic [WordW-1:0]   check_reg;
    logic [WordW-1:0]   last_check;
  } scan_state_t;

  typedef struct packed {
    logic             found;
    logic [OffW-1:0]  record_offset;
    logic [OffW-1:0]  next_offset;
    logic [WordW-1:0] stored_check;
  } scan_result_t;

endpackage

### src/fpbs_if.sv
// Request channels of the scanner: flash word input and scan report output.
interface fpbs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] flash_word;
  logic        region_start;

  modport source (output valid, output flash_word, output region_start, input ready);
  modport sink (input valid, input flash_word, input region_start, output ready);
endinterface

interface fpbs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] record_offset;
  logic [15:0] next_offset;
  logic [31:0] stored_check;

  modport source (output valid, output found, output record_offset, output next_offset,
                  output stored_check, input ready);
  modport sink (input valid, input found, input record_offset, input next_offset,
                input stored_check, output ready);
endinterface

### src/fpbs_step.sv
// Next-state and report logic for one flash word of the record scan.
module fpbs_step import fpbs_pkg::*; (
  input  cfg_t               cfg_i,
  input  scan_state_t        cur_i,
  input  logic [WordW-1:0]   word_i,
  input  logic               start_i,
  output scan_state_t        nxt_o,
  output logic               res_vld_o,
  output scan_result_t       res_o
);

  // Run the 0x1021 checksum over the low n bytes of a word, low byte first.
  function automatic logic [WordW-1:0] crc_word(input logic [WordW-1:0] crc,
                                                input logic [WordW-1:0] w,
                                                input logic [2:0] n);
    logic [WordW-1:0] r;
    logic [7:0]       byt;
    r = crc;
    for (int b = 0; b < 4; b++) begin
      byt = w[8*b +: 8];
      if (3'(b) < n) begin
        for (int k = 7; k >= 0; k--) begin
          if (r[15] ^ byt[k]) begin
            r = (r << 1) ^ 32'h0000_1021;
          end else begin
            r = r << 1;
          end
        end
      end
    end
    return r;
  endfunction

  logic [WirW-1:0]    body_words;
  logic [RegionW-1:0] region_clamp;
  logic signed [18:0] limit;
  logic               limit_pos;

  assign body_words   = WirW'(({1'b0, cfg_i.param_bytes} + 13'd3) >> 2);
  assign region_clamp = cfg_i.region_words[16] ? 17'h10000 : cfg_i.region_words;
  assign limit        = $signed({2'b00, region_clamp}) - 19'sd6
                        - $signed({8'b0, body_words});
  assign limit_pos    = limit > 19'sd0;

  scan_state_t  st;
  logic [12:0]  rem_bytes;
  logic [2:0]   n_bytes;
  logic [17:0]  next_off;
  logic         match;
  logic         in_body;

  always_comb begin
    st        = cur_i;
    res_vld_o = 1'b0;
    res_o     = '0;
    rem_bytes = {1'b0, cfg_i.param_bytes} - {cur_i.word_in_record - 11'd1, 2'b00};
    n_bytes   = (rem_bytes >= 13'd4) ? 3'd4 : rem_bytes[2:0];
    next_off  = {1'b0, cur_i.record_start} + {7'b0, body_words} + 18'd2;
    match     = 1'b0;
    in_body   = {1'b0, cur_i.word_in_record} < ({1'b0, body_words} + 12'd1);

    if (start_i) begin
      st.scan_offset    = '0;
      st.record_start   = '0;
      st.word_in_record = '0;
      st.last_check     = '0;
      st.phase          = PH_MARK;
      next_off          = {7'b0, body_words} + 18'd2;
      in_body           = 1'b1;
    end

    if (start_i && !limit_pos) begin
      // No room for any record: report at once.
      res_vld_o = 1'b1;
      st.phase  = PH_IDLE;
    end else begin
      case (st.phase)
        PH_IDLE: begin
        end
        PH_MARK: begin
          st.record_start   = st.scan_offset;
          st.scan_offset    = st.scan_offset + 17'd1;
          st.word_in_record = 11'd1;
          if (word_i == 32'hFFFF_FFFF) begin
            st.phase     = PH_CAND;
            st.check_reg = {16'b0, cfg_i.crc_seed};
          end else begin
            st.phase = PH_SKIP;
          end
        end
        PH_CAND, PH_SKIP: begin
          st.scan_offset = st.scan_offset + 17'd1;
          if (in_body) begin
            if (st.phase == PH_CAND) begin
              st.check_reg = crc_word(st.check_reg, word_i, n_bytes);
            end
            st.word_in_record = st.word_in_record + 11'd1;
          end else begin
            if (st.phase == PH_CAND) begin
              st.last_check = word_i;
              match         = (st.check_reg == word_i);
            end
            st.scan_offset    = next_off[16:0];
            st.word_in_record = '0;
            st.phase          = PH_MARK;
            if (match) begin
              res_vld_o = 1'b1;
              res_o.found = $signed({1'b0, next_off}) < limit;
              if (res_o.found) begin
                res_o.record_offset = st.record_start[15:0];
                res_o.next_offset   = next_off[15:0];
              end
              st.phase = PH_IDLE;
            end else if (!($signed({1'b0, next_off}) < limit)) begin
              res_vld_o = 1'b1;
              st.phase  = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_o.stored_check = st.last_check;
    nxt_o = st;
  end

endmodule

### src/flash_param_block_scanner_top.sv
// Top level of the flash parameter block scanner.
//
// Feed the words of a flash parameter region on in_ch_i, one request per word in
// ascending address order, with region_start high on the first word. The block
// walks the back-to-back records (marker, parameter words, checksum word), runs
// the 0x1021 checksum over each record whose marker is all ones, and stops at the
// first 32-bit checksum match or where no further record fits. It then sends one
// report request on out_ch_o: found, the record's offset, the offset past it and
// the last stored checksum word. Words after a report are dropped until a start word.
// Throughput: one word per cycle while out_ch_o does not stall, set by the
// combinational checksum network that folds up to four bytes per word between
// the input and state registers. The closing word waits in the input register,
// its report in the output register. While the receiver stalls, the report holds
// there; one more word is taken into the input register, then in_ch_i stalls.
// Reset clears the scan (idle, waiting for a start word) and loads the
// configuration defaults: 64 parameter bytes, 1024 region words, seed 0xA45E.
// Write configuration on cfg_we_i/cfg_idx_i/cfg_data_i only while no scan runs.
module flash_param_block_scanner_top import fpbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  fpbs_in_if.sink             in_ch_i,
  fpbs_out_if.source          out_ch_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg_q;
  scan_state_t      state_q, state_d;
  logic             in_vld_q;
  logic [WordW-1:0] in_word_q;
  logic             in_start_q;
  logic             out_vld_q;
  scan_result_t     out_q;
  scan_result_t     res;
  logic             res_vld;
  logic             fire;
  logic             in_ready;
  logic [WirW-1:0]  body_words;

  // Advance the held word when the report slot is free or being drained.
  assign fire     = in_vld_q && (!out_vld_q || out_ch_o.ready);
  assign in_ready = !in_vld_q || fire;
  assign in_ch_i.ready = in_ready;

  assign body_words = WirW'(({1'b0, cfg_q.param_bytes} + 13'd3) >> 2);

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.param_bytes  <= PbReset;
      cfg_q.region_words <= RegionReset;
      cfg_q.crc_seed     <= SeedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PARAM_BYTES:  cfg_q.param_bytes  <= cfg_data_i[PbW-1:0];
        CFG_REGION_WORDS: cfg_q.region_words <= cfg_data_i[RegionW-1:0];
        CFG_CRC_SEED:     cfg_q.crc_seed     <= cfg_data_i[SeedW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: take a word whenever none is held or the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch_i.valid) begin
      in_word_q  <= in_ch_i.flash_word;
      in_start_q <= in_ch_i.region_start;
    end
  end

  fpbs_step u_step (
    .cfg_i     (cfg_q),
    .cur_i     (state_q),
    .word_i    (in_word_q),
    .start_i   (in_start_q),
    .nxt_o     (state_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Scan state advances once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{scan_offset: '0, record_start: '0, word_in_record: '0,
                   phase: PH_IDLE, check_reg: '0, last_check: '0};
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Report register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld) begin
      out_q <= res;
    end
  end

  assign out_ch_o.valid         = out_vld_q;
  assign out_ch_o.found         = out_q.found;
  assign out_ch_o.record_offset = out_q.record_offset;
  assign out_ch_o.next_offset   = out_q.next_offset;
  assign out_ch_o.stored_check  = out_q.stored_check;

  // A new report only comes from a processed word.
  a_report_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire && res_vld))
    else $error("report appeared without a processed word");

  // Every report leaves the scan idle.
  a_idle_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_vld) |=> (state_q.phase == PH_IDLE))
    else $error("scan still active after report");

  // A found record spans marker, body and checksum word.
  a_found_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.found) |->
      (out_q.next_offset == 16'(out_q.record_offset + 16'(body_words) + 16'd2)))
    else $error("found record span mismatch");

  // Inside a candidate the word index never sits on the marker.
  a_cand_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_CAND) |-> (state_q.word_in_record != '0))
    else $error("candidate record lost its word index");

endmodule
